@@ hdl/irrt_pkg.sv @@
// Package for the I/O region reservation table.
// Holds shared widths, default sizes, operation and status codes and the compare result type.
// No dependencies.
`default_nettype none

package irrt_pkg;

  // Default sizing, handed down through top-level parameters
  localparam int unsigned TABLE_ENTRIES_DEF = 32;
  localparam int unsigned ADDR_WIDTH_DEF    = 16;

  // Fixed field widths of the request and response transfers
  localparam int unsigned REQ_TYPE_W = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned SLOT_IDX_W = 5;

  // Request operations; the remaining code is refused as busy
  typedef enum logic [REQ_TYPE_W-1:0] {
    OP_RESERVE = 2'd0,
    OP_CHECK   = 2'd1,
    OP_RELEASE = 2'd2
  } irrt_op_e;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BUSY    = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } irrt_status_e;

  // Result of comparing one table entry against the request range
  typedef struct packed {
    logic overlap;
    logic match;
  } irrt_hit_t;

endpackage

`default_nettype wire

@@ hdl/irrt_entry_cmp.sv @@
// Entry compare for the I/O region reservation table.
// Tests one stored range against the request range for overlap and exact match.
// Depends on irrt_pkg.
`default_nettype none

module irrt_entry_cmp import irrt_pkg::*; #(
  parameter int unsigned AddrW = ADDR_WIDTH_DEF
) (
  input  wire logic             entry_valid_i,
  input  wire logic [AddrW-1:0] entry_start_i,
  input  wire logic [AddrW:0]   entry_end_i,
  input  wire logic [AddrW-1:0] req_start_i,
  input  wire logic [AddrW+1:0] req_end_i,
  output irrt_hit_t             hit_o
);

  logic [AddrW+1:0] entry_start_ext;
  logic [AddrW:0]   req_start_ext;
  logic [AddrW+1:0] entry_end_ext;

  assign entry_start_ext = {2'b00, entry_start_i};
  assign req_start_ext   = {1'b0, req_start_i};
  assign entry_end_ext   = {1'b0, entry_end_i};

  // Half-open ranges overlap when each starts before the other ends
  assign hit_o.overlap = entry_valid_i && (entry_start_ext < req_end_i) &&
                         (req_start_ext < entry_end_i);

  // Same start and same end means same count; an empty request never matches
  assign hit_o.match = entry_valid_i && (entry_start_i == req_start_i) &&
                       (entry_end_ext == req_end_i);

endmodule

`default_nettype wire

@@ hdl/io_region_reservation_table.sv @@
// I/O region reservation table, top level.
// Depends on irrt_pkg and irrt_entry_cmp.
//
// Usage: a request transfer (req_type_i, region_start_i, region_count_i) on the
// input channel asks to reserve a range, check a range, or release an exact
// range. Each request gives one response transfer (status_o, slot_index_o).
// Both channels move a transfer at a rising edge where valid is high and stall
// is low.
// One request is handled at a time; the input stalls from the request transfer
// until its result has passed the finish step. The walk goes over the entry
// memory, which has one read port: one entry is read and compared per cycle,
// then the result and the write-back are formed in the finish step.
// Reset clears all entry valid bits at once, so the table starts empty with no
// clearing pass. A response waits in the output register while the receiver
// stalls; the next request can still be taken and walked meanwhile, and its
// result holds in the finish step until the output register frees up.
`default_nettype none

module io_region_reservation_table import irrt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned ADDR_WIDTH    = ADDR_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [REQ_TYPE_W-1:0]   req_type_i,
  input  wire logic [ADDR_WIDTH-1:0]   region_start_i,
  input  wire logic [ADDR_WIDTH:0]     region_count_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [STATUS_W-1:0]          status_o,
  output logic [SLOT_IDX_W-1:0]        slot_index_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [ADDR_WIDTH+1:0] AddrSpan = {2'b01, {ADDR_WIDTH{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Request registers
  logic [REQ_TYPE_W-1:0] op_q;
  logic [ADDR_WIDTH-1:0] req_start_q;
  logic [ADDR_WIDTH:0]   req_count_q;
  logic [ADDR_WIDTH+1:0] req_end_q;

  // Walk counters and compare stage
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic            rd_issue;
  logic [IdxW-1:0] rd_idx;
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            cmp_last;

  // Entry memory and valid bits
  logic [ADDR_WIDTH-1:0] slot_start_q [TABLE_ENTRIES];
  logic [ADDR_WIDTH:0]   slot_end_q   [TABLE_ENTRIES];
  logic [ADDR_WIDTH-1:0] rd_start_q;
  logic [ADDR_WIDTH:0]   rd_end_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic            mem_we;
  logic            vld_set;
  logic            vld_clr;

  // Accumulated walk results
  logic            free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic            match_found_q, match_found_d;
  logic [IdxW-1:0] match_idx_q, match_idx_d;
  logic            overlap_q, overlap_d;

  irrt_hit_t hit;

  // Response
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [SLOT_IDX_W-1:0] slot_q, slot_d;
  logic                  in_xfer;
  logic                  fin_go;
  logic                  range_bad;

  assign in_stall_o   = (state_q != S_IDLE);
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign slot_index_o = slot_q;

  assign rd_issue = (state_q == S_SCAN) && (rd_cnt_q < CntW'(TABLE_ENTRIES));
  assign rd_idx   = rd_cnt_q[IdxW-1:0];
  assign cmp_last = cmp_vld_q && (cmp_idx_q == IdxW'(TABLE_ENTRIES - 1));
  assign fin_go   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);
  assign range_bad = (req_count_q == '0) || (req_end_q > AddrSpan);

  irrt_entry_cmp #(
    .AddrW (ADDR_WIDTH)
  ) u_cmp (
    .entry_valid_i (valid_q[cmp_idx_q]),
    .entry_start_i (rd_start_q),
    .entry_end_i   (rd_end_q),
    .req_start_i   (req_start_q),
    .req_end_i     (req_end_q),
    .hit_o         (hit)
  );

  // Advance the state machine and the read counter
  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d  = S_SCAN;
          rd_cnt_d = '0;
        end
      end
      S_SCAN: begin
        if (rd_issue) rd_cnt_d = rd_cnt_q + CntW'(1);
        if (cmp_last) state_d = S_FIN;
      end
      S_FIN: begin
        if (fin_go) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Accumulate overlap, first free slot and first exact match
  always_comb begin
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    overlap_d     = overlap_q;
    if (in_xfer) begin
      free_found_d  = 1'b0;
      free_idx_d    = '0;
      match_found_d = 1'b0;
      match_idx_d   = '0;
      overlap_d     = 1'b0;
    end else if (cmp_vld_q) begin
      if (!free_found_q && !valid_q[cmp_idx_q]) begin
        free_found_d = 1'b1;
        free_idx_d   = cmp_idx_q;
      end
      if (!match_found_q && hit.match) begin
        match_found_d = 1'b1;
        match_idx_d   = cmp_idx_q;
      end
      if (hit.overlap) overlap_d = 1'b1;
    end
  end

  // Form the response and the write-back
  always_comb begin
    status_d = ST_BUSY;
    slot_d   = '0;
    mem_we   = 1'b0;
    vld_set  = 1'b0;
    vld_clr  = 1'b0;
    unique case (op_q)
      OP_RESERVE: begin
        if (!free_found_q) begin
          status_d = ST_FULL;
        end else if (!range_bad && !overlap_q) begin
          status_d = ST_OK;
          slot_d   = SLOT_IDX_W'(free_idx_q);
          mem_we   = fin_go;
          vld_set  = fin_go;
        end
      end
      OP_CHECK: begin
        status_d = (range_bad || overlap_q) ? ST_BUSY : ST_OK;
      end
      OP_RELEASE: begin
        if (match_found_q) begin
          status_d = ST_OK;
          slot_d   = SLOT_IDX_W'(match_idx_q);
          vld_clr  = fin_go;
        end else begin
          status_d = ST_NOMATCH;
        end
      end
      default: status_d = ST_BUSY;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      rd_cnt_q      <= '0;
      cmp_vld_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      valid_q       <= '0;
      free_found_q  <= 1'b0;
      match_found_q <= 1'b0;
      overlap_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      rd_cnt_q      <= rd_cnt_d;
      cmp_vld_q     <= rd_issue;
      free_found_q  <= free_found_d;
      match_found_q <= match_found_d;
      overlap_q     <= overlap_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (vld_set) valid_q[free_idx_q] <= 1'b1;
      if (vld_clr) valid_q[match_idx_q] <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q        <= req_type_i;
      req_start_q <= region_start_i;
      req_count_q <= region_count_i;
      req_end_q   <= {2'b00, region_start_i} + {1'b0, region_count_i};
    end
    cmp_idx_q   <= rd_idx;
    free_idx_q  <= free_idx_d;
    match_idx_q <= match_idx_d;
    if (fin_go) begin
      status_q <= status_d;
      slot_q   <= slot_d;
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_start_q[free_idx_q] <= req_start_q;
      slot_end_q[free_idx_q]   <= req_end_q[ADDR_WIDTH:0];
    end
    if (rd_issue) begin
      rd_start_q <= slot_start_q[rd_idx];
      rd_end_q   <= slot_end_q[rd_idx];
    end
  end

endmodule

`default_nettype wire

@@ hdl/irrt_checker.sv @@
// Port-level checker for the I/O region reservation table.
// Watches the top-level ports only; bound to the top level below.
// Depends on irrt_pkg and io_region_reservation_table.
`default_nettype none

module irrt_checker import irrt_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [STATUS_W-1:0]   status_o,
  input wire logic [SLOT_IDX_W-1:0] slot_index_o
);

  // A stalled response holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
    $stable(slot_index_o))
    else $error("response changed while stalled");

  // A refused request names no slot
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> slot_index_o == '0)
    else $error("slot index set on refused request");

  // A taken request blocks the input during the table walk
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken during table walk");

  // A new response only appears at the end of a walk
  a_resp_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("response without a walk");

endmodule

bind io_region_reservation_table irrt_checker u_irrt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .slot_index_o (slot_index_o)
);

`default_nettype wire
